FILE: hdl/spgr_pkg.sv
// ============================================================================
// spgr_pkg: shared definitions of the shortest-path gather stage
// Sizes, mode and operation codes, the command that travels from the front
// end to the back end, the stored vertex entry, and saturating helpers.
// ============================================================================
package spgr_pkg;

  // Store geometry. Interval size and interval count are powers of two.
  localparam int VERTEX_BITS    = 16;
  localparam int INTERVAL_SIZE  = 256;
  localparam int INTERVAL_COUNT = 256;

  localparam int IVL_SHIFT = $clog2(INTERVAL_SIZE);
  localparam int IVL_BITS  = (INTERVAL_COUNT > 1) ? $clog2(INTERVAL_COUNT) : 1;
  localparam int OUTST_W   = $clog2(INTERVAL_COUNT + 1);
  localparam int CLR_BITS  = (VERTEX_BITS > IVL_BITS) ? VERTEX_BITS : IVL_BITS;

  // Field widths.
  localparam int NV_W        = VERTEX_BITS + 1;
  localparam int MODE_W      = 3;
  localparam int DIST_W      = 32;
  localparam int IVL_FIELD_W = 8;
  localparam int LEVEL_W     = 16;
  localparam int CNT_W       = 24;

  localparam logic [NV_W-1:0]    NV_RESET  = NV_W'(1) << VERTEX_BITS;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // Input mode codes.
  localparam logic [MODE_W-1:0] MODE_SEED  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RELAX = 3'd1;
  localparam logic [MODE_W-1:0] MODE_END   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TAKE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

  // Queue between front and back end.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Operations after classification.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEED,
    OP_RELAX,
    OP_END,
    OP_TAKE,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic                   status;
    logic [VERTEX_BITS-1:0] vertex;
    logic [DIST_W-1:0]      distance;
    logic [IVL_BITS-1:0]    ivl;
  } cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0]  cost;
    logic [LEVEL_W-1:0] level;
    logic               unreached;
  } vtx_entry_t;

  localparam vtx_entry_t VTX_RESET = '{cost: '0, level: '0, unreached: 1'b1};

  typedef struct packed {
    logic               status;
    logic               improved;
    logic [DIST_W-1:0]  vertex_distance;
    logic [LEVEL_W-1:0] vertex_level;
    logic               unreached;
    logic [CNT_W-1:0]   count;
    logic               any_active;
    logic [LEVEL_W-1:0] level_now;
  } rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc_cnt(input logic [CNT_W-1:0] x);
    return (x == CNT_MAX) ? x : x + CNT_W'(1);
  endfunction

  function automatic logic [LEVEL_W-1:0] sat_inc_lvl(input logic [LEVEL_W-1:0] x);
    return (x == LEVEL_MAX) ? x : x + LEVEL_W'(1);
  endfunction

endpackage

FILE: hdl/spgr_if.sv
// ============================================================================
// spgr_if: request and response channels of the shortest-path gather stage
// Valid/ready channels; an item moves when valid and ready are both high.
// ============================================================================
interface spgr_req_if;
  logic                               valid;
  logic                               ready;
  logic [spgr_pkg::MODE_W-1:0]        mode;
  logic [spgr_pkg::VERTEX_BITS-1:0]   vertex;
  logic [spgr_pkg::DIST_W-1:0]        distance;
  logic [spgr_pkg::IVL_FIELD_W-1:0]   interval;

  modport source (output valid, mode, vertex, distance, interval, input ready);
  modport sink   (input valid, mode, vertex, distance, interval, output ready);
endinterface

interface spgr_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic                           improved;
  logic [spgr_pkg::DIST_W-1:0]    vertex_distance;
  logic [spgr_pkg::LEVEL_W-1:0]   vertex_level;
  logic                           unreached;
  logic [spgr_pkg::CNT_W-1:0]     count;
  logic                           any_active;
  logic [spgr_pkg::LEVEL_W-1:0]   level_now;

  modport source (output valid, status, improved, vertex_distance, vertex_level,
                  unreached, count, any_active, level_now, input ready);
  modport sink   (input valid, status, improved, vertex_distance, vertex_level,
                  unreached, count, any_active, level_now, output ready);
endinterface

FILE: hdl/spgr_front.sv
// ============================================================================
// spgr_front: request front end
// Holds the vertex-count register, accepts items, checks ranges and turns
// each item into a command for the back end.
// ============================================================================
module spgr_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [spgr_pkg::NV_W-1:0]   cfg_wdata_i,
  input  logic                        clearing_i,
  input  logic                        fifo_full_i,
  spgr_req_if.sink                    req,
  output logic                        push_o,
  output spgr_pkg::cmd_t              cmd_o
);

  logic [spgr_pkg::NV_W-1:0] nv_q, nv_d;
  logic                      in_range;
  logic                      ivl_ok;
  logic [spgr_pkg::VERTEX_BITS+spgr_pkg::IVL_BITS-1:0] vtx_shift;
  logic [spgr_pkg::IVL_FIELD_W+spgr_pkg::IVL_BITS-1:0] take_wide;

  assign nv_d = cfg_we_i ? cfg_wdata_i : nv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= spgr_pkg::NV_RESET;
    end else begin
      nv_q <= nv_d;
    end
  end

  assign in_range  = {1'b0, req.vertex} < nv_q;
  assign ivl_ok    = 32'(req.interval) < 32'(spgr_pkg::INTERVAL_COUNT);
  assign vtx_shift = {spgr_pkg::IVL_BITS'(0), req.vertex} >> spgr_pkg::IVL_SHIFT;
  assign take_wide = {spgr_pkg::IVL_BITS'(0), req.interval};

  always_comb begin
    cmd_o.op       = spgr_pkg::OP_NONE;
    cmd_o.status   = 1'b0;
    cmd_o.vertex   = req.vertex;
    cmd_o.distance = req.distance;
    cmd_o.ivl      = vtx_shift[spgr_pkg::IVL_BITS-1:0];
    unique case (req.mode)
      spgr_pkg::MODE_SEED: begin
        cmd_o.op     = in_range ? spgr_pkg::OP_SEED : spgr_pkg::OP_READ;
        cmd_o.status = !in_range;
      end
      spgr_pkg::MODE_RELAX: begin
        cmd_o.op     = in_range ? spgr_pkg::OP_RELAX : spgr_pkg::OP_READ;
        cmd_o.status = !in_range;
      end
      spgr_pkg::MODE_END: begin
        cmd_o.op = spgr_pkg::OP_END;
      end
      spgr_pkg::MODE_TAKE: begin
        // A take beyond the last interval reports zero and changes nothing.
        cmd_o.op  = ivl_ok ? spgr_pkg::OP_TAKE : spgr_pkg::OP_NONE;
        cmd_o.ivl = take_wide[spgr_pkg::IVL_BITS-1:0];
      end
      spgr_pkg::MODE_READ: begin
        cmd_o.op     = spgr_pkg::OP_READ;
        cmd_o.status = !in_range;
      end
      default: begin
        cmd_o.op = spgr_pkg::OP_NONE;
      end
    endcase
  end

  assign req.ready = !clearing_i && !fifo_full_i;
  assign push_o    = req.valid && req.ready;

endmodule

FILE: hdl/spgr_fifo.sv
// ============================================================================
// spgr_fifo: command queue
// Small first-in first-out queue that decouples the front and back ends.
// ============================================================================
module spgr_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spgr_pkg::cmd_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output spgr_pkg::cmd_t  pop_data_o,
  output logic            empty_o
);

  spgr_pkg::cmd_t                    mem_q [spgr_pkg::FIFO_DEPTH];
  logic [spgr_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [spgr_pkg::FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [spgr_pkg::FIFO_CNT_W-1:0]   cnt_q, cnt_d;

  localparam logic [spgr_pkg::FIFO_PTR_W-1:0] PtrLast =
    spgr_pkg::FIFO_PTR_W'(spgr_pkg::FIFO_DEPTH - 1);

  assign full_o     = cnt_q == spgr_pkg::FIFO_CNT_W'(spgr_pkg::FIFO_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hdl/spgr_back.sv
// ============================================================================
// spgr_back: execution back end
// Owns the vertex and interval memories, clears them after reset, and runs
// each command as a read followed by a write, into the response register.
// ============================================================================
module spgr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  spgr_pkg::cmd_t  head_i,
  output logic            pop_o,
  output logic            clearing_o,
  spgr_rsp_if.source      rsp
);

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StExec  = 2'd2;

  localparam int VtxDepth = 1 << spgr_pkg::VERTEX_BITS;

  logic [1:0]                         state_q, state_d;
  logic [spgr_pkg::CLR_BITS-1:0]      clr_q, clr_d;
  spgr_pkg::cmd_t                     cmd_q;

  spgr_pkg::vtx_entry_t               vtx_mem [VtxDepth];
  logic [spgr_pkg::CNT_W-1:0]         ivl_mem [spgr_pkg::INTERVAL_COUNT];
  spgr_pkg::vtx_entry_t               vtx_rd_q;
  logic [spgr_pkg::CNT_W-1:0]         ivl_rd_q;

  logic                               vtx_we;
  logic [spgr_pkg::VERTEX_BITS-1:0]   vtx_waddr;
  spgr_pkg::vtx_entry_t               vtx_wdata;
  logic                               ivl_we;
  logic [spgr_pkg::IVL_BITS-1:0]      ivl_waddr;
  logic [spgr_pkg::CNT_W-1:0]         ivl_wdata;

  logic [spgr_pkg::LEVEL_W-1:0]       level_q, level_d;
  logic [spgr_pkg::CNT_W-1:0]         upd_q, upd_d;
  logic [spgr_pkg::OUTST_W-1:0]       outst_q, outst_d;

  logic                               valid_q, valid_d;
  spgr_pkg::rsp_t                     rsp_q, rsp_d;

  logic                               vmode;
  logic                               improved;
  logic [spgr_pkg::CNT_W-1:0]         count;
  spgr_pkg::vtx_entry_t               entry_new;

  assign clearing_o = state_q == StClear;
  assign pop_o      = (state_q == StIdle) && !empty_i && (!valid_q || rsp.ready);

  // Sequencer: clear pass, then read on pop and write in the cycle after.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (pop_o) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    vtx_we    = 1'b0;
    vtx_waddr = cmd_q.vertex;
    ivl_we    = 1'b0;
    ivl_waddr = cmd_q.ivl;
    ivl_wdata = '0;
    level_d   = level_q;
    upd_d     = upd_q;
    outst_d   = outst_q;
    improved  = 1'b0;
    count     = '0;
    entry_new = vtx_rd_q;
    vmode     = (cmd_q.op == spgr_pkg::OP_SEED) || (cmd_q.op == spgr_pkg::OP_RELAX) ||
                (cmd_q.op == spgr_pkg::OP_READ);

    if (state_q == StClear) begin
      vtx_we    = 1'b1;
      vtx_waddr = clr_q[spgr_pkg::VERTEX_BITS-1:0];
      entry_new = spgr_pkg::VTX_RESET;
      ivl_we    = 1'b1;
      ivl_waddr = clr_q[spgr_pkg::IVL_BITS-1:0];
    end else if (state_q == StExec) begin
      unique case (cmd_q.op)
        spgr_pkg::OP_SEED: begin
          entry_new = '{cost: '0, level: spgr_pkg::LEVEL_W'(1), unreached: 1'b0};
          vtx_we    = 1'b1;
          ivl_we    = 1'b1;
          ivl_wdata = spgr_pkg::CNT_W'(1);
          if (ivl_rd_q == '0) begin
            outst_d = outst_q + 1'b1;
          end
          level_d = spgr_pkg::LEVEL_W'(1);
          upd_d   = '0;
        end
        spgr_pkg::OP_RELAX: begin
          if (vtx_rd_q.unreached || (vtx_rd_q.cost > cmd_q.distance)) begin
            entry_new = '{cost: cmd_q.distance, level: spgr_pkg::sat_inc_lvl(level_q),
                          unreached: 1'b0};
            vtx_we    = 1'b1;
            ivl_we    = 1'b1;
            ivl_wdata = spgr_pkg::sat_inc_cnt(ivl_rd_q);
            if (ivl_rd_q == '0) begin
              outst_d = outst_q + 1'b1;
            end
            upd_d    = spgr_pkg::sat_inc_cnt(upd_q);
            improved = 1'b1;
          end
        end
        spgr_pkg::OP_END: begin
          count   = upd_q;
          upd_d   = '0;
          level_d = spgr_pkg::sat_inc_lvl(level_q);
        end
        spgr_pkg::OP_TAKE: begin
          count  = ivl_rd_q;
          ivl_we = 1'b1;
          if ((ivl_rd_q != '0) && (outst_q != '0)) begin
            outst_d = outst_q - 1'b1;
          end
        end
        spgr_pkg::OP_READ, spgr_pkg::OP_NONE: begin
          count = '0;
        end
        default: begin
          count = '0;
        end
      endcase
    end
    vtx_wdata = entry_new;
  end

  // Response register.
  always_comb begin
    rsp_d   = rsp_q;
    valid_d = valid_q;
    if (valid_q && rsp.ready) begin
      valid_d = 1'b0;
    end
    if (state_q == StExec) begin
      valid_d               = 1'b1;
      rsp_d.status          = cmd_q.status;
      rsp_d.improved        = improved;
      rsp_d.vertex_distance = vmode ? entry_new.cost : '0;
      rsp_d.vertex_level    = vmode ? entry_new.level : '0;
      rsp_d.unreached       = vmode ? entry_new.unreached : 1'b0;
      rsp_d.count           = count;
      rsp_d.any_active      = outst_d != '0;
      rsp_d.level_now       = level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      level_q <= '0;
      upd_q   <= '0;
      outst_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      level_q <= level_d;
      upd_q   <= upd_d;
      outst_q <= outst_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (pop_o) begin
      cmd_q <= head_i;
    end
  end

  // Vertex memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (vtx_we) begin
      vtx_mem[vtx_waddr] <= vtx_wdata;
    end
    if (pop_o) begin
      vtx_rd_q <= vtx_mem[head_i.vertex];
    end
  end

  // Interval counter memory.
  always_ff @(posedge clk_i) begin
    if (ivl_we) begin
      ivl_mem[ivl_waddr] <= ivl_wdata;
    end
    if (pop_o) begin
      ivl_rd_q <= ivl_mem[head_i.ivl];
    end
  end

  assign rsp.valid           = valid_q;
  assign rsp.status          = rsp_q.status;
  assign rsp.improved        = rsp_q.improved;
  assign rsp.vertex_distance = rsp_q.vertex_distance;
  assign rsp.vertex_level    = rsp_q.vertex_level;
  assign rsp.unreached       = rsp_q.unreached;
  assign rsp.count           = rsp_q.count;
  assign rsp.any_active      = rsp_q.any_active;
  assign rsp.level_now       = rsp_q.level_now;

endmodule

FILE: hdl/shortest_path_gather_relax.sv
// ============================================================================
// shortest_path_gather_relax: gather stage of an edge-centric SSSP engine
// Top level: front end, command queue and back end with the vertex store.
// ============================================================================
// After reset the block first walks through its vertex memory and interval
// counters to set every vertex to unreached and every counter to zero,
// one vertex entry at a time, and request ready stays low until this
// clearing pass is done, while writes to the vertex-count register are
// taken as usual. After that the back end handles each item by reading
// its vertex entry and interval counter from memory, then computing the
// update and writing both back; it does not start the next item before
// the last one is written back. A two-entry command queue lets the front
// end keep taking items while the back end works. The back end only
// starts the next item when the response register is empty or its result
// is taken in that same cycle, so a stalled result holds the back end
// and, once the queue is full, the request side too. Items come out in the
// order they were accepted, one result each.
// The vertex-count register should only be written while no item is in
// flight.
module shortest_path_gather_relax (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [spgr_pkg::NV_W-1:0]   cfg_wdata_i,
  spgr_req_if.sink                    req_i,
  spgr_rsp_if.source                  rsp_o
);

  logic            push;
  logic            pop;
  logic            fifo_full;
  logic            fifo_empty;
  logic            clearing;
  spgr_pkg::cmd_t  push_cmd;
  spgr_pkg::cmd_t  head_cmd;

  // The front end checks each vertex item against the vertex count and classifies
  // it; out-of-range seeds and relaxes become plain reads flagged with error
  // status, and takes of a nonexistent interval become no-ops.
  spgr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .clearing_i  (clearing),
    .fifo_full_i (fifo_full),
    .req         (req_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  spgr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .empty_o     (fifo_empty)
  );

  // The back end holds the vertex memory, the interval counters, the current
  // level, the level update count and the number of intervals that still
  // have active vertices.
  spgr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (fifo_empty),
    .head_i     (head_cmd),
    .pop_o      (pop),
    .clearing_o (clearing),
    .rsp        (rsp_o)
  );

endmodule

FILE: hdl/spgr_checker.sv
// ============================================================================
// spgr_checker: port-level checks of the shortest-path gather stage
// Watches the request and response channels of the top level over time.
// ============================================================================
module spgr_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  logic                           req_ready_i,
  input  logic                           rsp_valid_i,
  input  logic                           rsp_ready_i,
  input  logic                           rsp_status_i,
  input  logic                           rsp_improved_i,
  input  logic                           rsp_unreached_i,
  input  logic [spgr_pkg::LEVEL_W-1:0]   rsp_vertex_level_i,
  input  logic [spgr_pkg::CNT_W-1:0]     rsp_count_i,
  input  logic [spgr_pkg::LEVEL_W-1:0]   rsp_level_now_i
);

  logic [3:0] pend_q, pend_d;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (req_acc && !rsp_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (rsp_acc && !req_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // The memories are cleared after reset before any item is taken.
  a_no_accept_after_reset: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !req_ready_i)
    else $error("request taken right after reset");

  // A result only appears for an item that was accepted and not yet answered.
  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != '0)
    else $error("result without a pending item");

  // A waiting result stays valid and holds its count, levels and improved flag.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_count_i) &&
      $stable(rsp_level_now_i) && $stable(rsp_vertex_level_i) && $stable(rsp_improved_i))
    else $error("stalled result changed");

  // An improving relax leaves a reached vertex with a nonzero level.
  a_improved_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_improved_i |->
      !rsp_status_i && !rsp_unreached_i && (rsp_vertex_level_i != '0))
    else $error("improved result with inconsistent vertex");

endmodule

bind shortest_path_gather_relax spgr_checker u_spgr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.status),
  .rsp_improved_i     (rsp_o.improved),
  .rsp_unreached_i    (rsp_o.unreached),
  .rsp_vertex_level_i (rsp_o.vertex_level),
  .rsp_count_i        (rsp_o.count),
  .rsp_level_now_i    (rsp_o.level_now)
);
